// ----- hdl/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY = 128;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCNT_W   = 8;
  localparam int STAT_W   = 2;
  localparam int ODATA_W  = 48;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ----- hdl/mhpq_cell.sv -----
// One slot of the sorted key chain: holds a key, shifts or takes the new key.
module mhpq_cell (
  input  logic                             clk,
  input  mhpq_pkg::cell_ctl_t              ctl,
  input  logic                             occ,
  input  logic signed [mhpq_pkg::KEY_W-1:0] left_key,
  input  logic                             left_take,
  input  logic signed [mhpq_pkg::KEY_W-1:0] right_key,
  output logic signed [mhpq_pkg::KEY_W-1:0] key_o,
  output logic                             take_o
);

  logic signed [mhpq_pkg::KEY_W-1:0] key_r;
  logic signed [mhpq_pkg::KEY_W-1:0] key_nxt;

  // Slot is displaced by the new key when empty or holding a smaller key.
  assign take_o = !occ || (ctl.key > key_r);
  assign key_o  = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && take_o) begin
      // left neighbor also displaced: its key moves down here
      key_nxt = left_take ? left_key : ctl.key;
    end else if (ctl.ext) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- hdl/max_heap_priority_queue.sv -----
// Top level: bounded max priority queue built from a chain of sorted key cells.
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; each is a single shift or insert
//   step across the cell chain, and the output register is the only hold point.
// Reset (rst_n, synchronous, active low) clears the entry count and the output
//   valid flag; cell contents are not cleared and take effect once written.
module max_heap_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mhpq_pkg::KEY_W-1:0]    in_tdata,   // [31:0] key
  input  logic                          in_tuser,   // [0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mhpq_pkg::ODATA_W-1:0]  out_tdata   // [31:0] max_key, [33:32] status,
                                                    // [41:34] count, [47:42] zero
);

  localparam int CAP = mhpq_pkg::CAPACITY;

  logic [mhpq_pkg::CNT_W-1:0]  count_r;
  logic [mhpq_pkg::CNT_W-1:0]  count_nxt;
  logic                        out_valid_r;
  logic signed [mhpq_pkg::KEY_W-1:0] out_key_r;
  logic signed [mhpq_pkg::KEY_W-1:0] out_key_nxt;
  mhpq_pkg::status_t           out_status_r;
  mhpq_pkg::status_t           out_status_nxt;
  logic [mhpq_pkg::OCNT_W-1:0] out_count_r;

  logic accept;
  logic is_ext;
  logic full;
  logic empty;
  mhpq_pkg::cell_ctl_t ctl;

  logic signed [mhpq_pkg::KEY_W-1:0] cell_key [CAP];
  logic                              cell_take [CAP];
  logic                              cell_occ [CAP];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_ext    = (in_tuser == mhpq_pkg::MODE_EXTRACT);
  assign full      = (count_r == mhpq_pkg::CNT_W'(CAP));
  assign empty     = (count_r == '0);

  assign ctl.ins = accept && !is_ext && !full;
  assign ctl.ext = accept && is_ext && !empty;
  assign ctl.key = $signed(in_tdata);

  genvar i;
  generate
    for (i = 0; i < CAP; i++) begin : g_cell
      assign cell_occ[i] = (count_r > mhpq_pkg::CNT_W'(i));
      if (i == 0) begin : g_head
        mhpq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_key  (ctl.key),
          .left_take (1'b0),
          .right_key (cell_key[i+1]),
          .key_o     (cell_key[i]),
          .take_o    (cell_take[i])
        );
      end else if (i == CAP - 1) begin : g_tail
        mhpq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_key  (cell_key[i-1]),
          .left_take (cell_take[i-1]),
          .right_key (cell_key[i]),
          .key_o     (cell_key[i]),
          .take_o    (cell_take[i])
        );
      end else begin : g_mid
        mhpq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_key  (cell_key[i-1]),
          .left_take (cell_take[i-1]),
          .right_key (cell_key[i+1]),
          .key_o     (cell_key[i]),
          .take_o    (cell_take[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt      = count_r;
    out_key_nxt    = '0;
    out_status_nxt = mhpq_pkg::ST_OK;
    if (is_ext) begin
      if (empty) begin
        out_key_nxt    = mhpq_pkg::EMPTY_KEY;
        out_status_nxt = mhpq_pkg::ST_EMPTY;
      end else begin
        out_key_nxt = cell_key[0];
        count_nxt   = count_r - mhpq_pkg::CNT_W'(1);
      end
    end else begin
      if (full) begin
        out_status_nxt = mhpq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + mhpq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key_r    <= out_key_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= mhpq_pkg::OCNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mhpq_pkg::ODATA_W - mhpq_pkg::KEY_W - mhpq_pkg::STAT_W
                         - mhpq_pkg::OCNT_W){1'b0}},
                       out_count_r, out_status_r, out_key_r};

endmodule
